### sv/ymr_pkg.sv
// ----------------------------------------------------------------------------
// ymr_pkg
// Shared codes, types and the CRC-16/XMODEM byte update for the YMODEM
// packet receiver.
// ----------------------------------------------------------------------------
package ymr_pkg;

    localparam int SMALL_BLOCK_DEF = 128;
    localparam int LARGE_BLOCK_DEF = 1024;

    // control characters
    localparam logic [7:0] CH_SOH      = 8'h01;
    localparam logic [7:0] CH_STX      = 8'h02;
    localparam logic [7:0] CH_EOT      = 8'h04;
    localparam logic [7:0] CH_CA       = 8'h18;
    localparam logic [7:0] CH_ABORT_UP = 8'h41;
    localparam logic [7:0] CH_ABORT_LO = 8'h61;

    // status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_EOT       = 4'd1;
    localparam logic [3:0] ST_CANCEL    = 4'd2;
    localparam logic [3:0] ST_ABORT     = 4'd3;
    localparam logic [3:0] ST_BADSTART  = 4'd4;
    localparam logic [3:0] ST_SEQ       = 4'd5;
    localparam logic [3:0] ST_CRC       = 4'd6;
    localparam logic [3:0] ST_TIMEOUT   = 4'd7;
    localparam logic [3:0] ST_BADCANCEL = 4'd8;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [9:0]  byte_index;
        logic [3:0]  status;
        logic [7:0]  seq_number;
        logic [10:0] frame_len;
    } t_result;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### sv/ymodem_packet_receiver.sv
// Path: an input byte is held in the input register, and its result then in
// the result register. Throughput: one transaction per cycle unless o_stall
// is high; both registers let a new byte enter while a result waits downstream.
// Reset: synchronous active-low i_rst_n returns the parser to idle (waiting
// for a start byte) and empties both registers.
// ----------------------------------------------------------------------------
// ymodem_packet_receiver
// Parses YMODEM packets (SOH/STX framing, sequence check, CRC-16/XMODEM),
// forwarding payload bytes, a final packet status and control/timeout statuses.
// ----------------------------------------------------------------------------
module ymodem_packet_receiver #(
    parameter int SMALL_BLOCK = ymr_pkg::SMALL_BLOCK_DEF,
    parameter int LARGE_BLOCK = ymr_pkg::LARGE_BLOCK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [9:0]  o_byte_index,
    output logic [3:0]  o_status,
    output logic [7:0]  o_seq_number,
    output logic [10:0] o_frame_len
);
    import ymr_pkg::*;

    logic       r_in_valid;
    logic       r_in_mode;
    logic [7:0] r_in_byte;

    logic    out_hold;
    logic    fire;
    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign fire    = r_in_valid & ~out_hold;
    assign o_stall = r_in_valid & out_hold;
    assign accept  = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_mode <= i_mode;
            r_in_byte <= i_rx_byte;
        end
    end

    ymr_parser #(
        .SMALL_BLOCK(SMALL_BLOCK),
        .LARGE_BLOCK(LARGE_BLOCK)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_mode      (r_in_mode),
        .i_rx_byte   (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ymr_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire & res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_hold  (out_hold),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_kind          = out_res.kind;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_byte_index    = out_res.byte_index;
    assign o_status        = out_res.status;
    assign o_seq_number    = out_res.seq_number;
    assign o_frame_len     = out_res.frame_len;

endmodule

### sv/ymr_parser.sv
// ----------------------------------------------------------------------------
// ymr_parser
// Packet phase tracking, sequence check and running CRC. Produces at most
// one result per processed transaction.
// ----------------------------------------------------------------------------
module ymr_parser #(
    parameter int SMALL_BLOCK = ymr_pkg::SMALL_BLOCK_DEF,
    parameter int LARGE_BLOCK = ymr_pkg::LARGE_BLOCK_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_mode,
    input  logic [7:0]        i_rx_byte,
    output logic              o_res_valid,
    output ymr_pkg::t_result  o_res
);
    import ymr_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_CANCEL = 3'd1;
    localparam logic [2:0] PH_SEQ    = 3'd2;
    localparam logic [2:0] PH_SEQC   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CRCH   = 3'd5;
    localparam logic [2:0] PH_CRCL   = 3'd6;

    localparam logic [10:0] SMALL_LEN = 11'(SMALL_BLOCK);
    localparam logic [10:0] LARGE_LEN = 11'(LARGE_BLOCK);

    logic [2:0]  r_phase,     n_phase;
    logic        r_large,     n_large;
    logic [9:0]  r_count,     n_count;
    logic [7:0]  r_seq,       n_seq;
    logic        r_seq_ok,    n_seq_ok;
    logic [15:0] r_crc,       n_crc;
    logic [7:0]  r_crc_hi,    n_crc_hi;

    logic [10:0] size;
    logic [10:0] count_inc;
    logic [15:0] crc_next;

    assign size      = r_large ? LARGE_LEN : SMALL_LEN;
    assign count_inc = {1'b0, r_count} + 11'd1;
    assign crc_next  = crc16_byte(r_crc, i_rx_byte);

    always_comb begin
        n_phase  = r_phase;
        n_large  = r_large;
        n_count  = r_count;
        n_seq    = r_seq;
        n_seq_ok = r_seq_ok;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;

        o_res_valid         = 1'b0;
        o_res.kind          = KIND_STATUS;
        o_res.payload_byte  = 8'h00;
        o_res.byte_index    = 10'd0;
        o_res.status        = ST_OK;
        o_res.seq_number    = 8'h00;
        o_res.frame_len     = 11'd0;

        if (i_mode) begin
            o_res_valid  = 1'b1;
            o_res.status = ST_TIMEOUT;
            n_phase      = PH_IDLE;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_rx_byte == CH_SOH || i_rx_byte == CH_STX) begin
                        n_large  = (i_rx_byte == CH_STX);
                        n_count  = 10'd0;
                        n_crc    = 16'h0000;
                        n_seq    = 8'h00;
                        n_seq_ok = 1'b0;
                        n_crc_hi = 8'h00;
                        n_phase  = PH_SEQ;
                    end else if (i_rx_byte == CH_CA) begin
                        n_phase = PH_CANCEL;
                    end else begin
                        o_res_valid = 1'b1;
                        if (i_rx_byte == CH_EOT) begin
                            o_res.status = ST_EOT;
                        end else if (i_rx_byte == CH_ABORT_UP || i_rx_byte == CH_ABORT_LO) begin
                            o_res.status = ST_ABORT;
                        end else begin
                            o_res.status = ST_BADSTART;
                        end
                    end
                end
                PH_CANCEL: begin
                    o_res_valid  = 1'b1;
                    o_res.status = (i_rx_byte == CH_CA) ? ST_CANCEL : ST_BADCANCEL;
                    n_phase      = PH_IDLE;
                end
                PH_SEQ: begin
                    n_seq   = i_rx_byte;
                    n_phase = PH_SEQC;
                end
                PH_SEQC: begin
                    n_seq_ok = (r_seq == ~i_rx_byte);
                    n_phase  = PH_DATA;
                end
                PH_DATA: begin
                    n_crc              = crc_next;
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_PAYLOAD;
                    o_res.payload_byte = i_rx_byte;
                    o_res.byte_index   = r_count;
                    o_res.seq_number   = r_seq;
                    if (count_inc >= size) begin
                        n_phase = PH_CRCH;
                    end else begin
                        n_count = count_inc[9:0];
                    end
                end
                PH_CRCH: begin
                    n_crc_hi = i_rx_byte;
                    n_phase  = PH_CRCL;
                end
                PH_CRCL: begin
                    o_res_valid      = 1'b1;
                    o_res.seq_number = r_seq;
                    n_phase          = PH_IDLE;
                    if (!r_seq_ok) begin
                        o_res.status = ST_SEQ;
                    end else if ({r_crc_hi, i_rx_byte} != r_crc) begin
                        o_res.status = ST_CRC;
                    end else begin
                        o_res.status    = ST_OK;
                        o_res.frame_len = size;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_large  <= 1'b0;
            r_count  <= 10'd0;
            r_seq    <= 8'h00;
            r_seq_ok <= 1'b0;
            r_crc    <= 16'h0000;
            r_crc_hi <= 8'h00;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_large  <= n_large;
            r_count  <= n_count;
            r_seq    <= n_seq;
            r_seq_ok <= n_seq_ok;
            r_crc    <= n_crc;
            r_crc_hi <= n_crc_hi;
        end
    end

endmodule

### sv/ymr_out_reg.sv
// ----------------------------------------------------------------------------
// ymr_out_reg
// Result register on the output channel; holds a result while stalled.
// ----------------------------------------------------------------------------
module ymr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ymr_pkg::t_result  i_res,
    input  logic              i_stall,
    output logic              o_hold,
    output logic              o_valid,
    output ymr_pkg::t_result  o_res
);
    import ymr_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_hold  = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### sv/ymr_checker.sv
// ----------------------------------------------------------------------------
// ymr_checker
// Port-level checks on the output channel of the YMODEM packet receiver.
// ----------------------------------------------------------------------------
module ymr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_kind,
    input logic [7:0]  o_payload_byte,
    input logic [9:0]  o_byte_index,
    input logic [3:0]  o_status,
    input logic [7:0]  o_seq_number,
    input logic [10:0] o_frame_len
);
    import ymr_pkg::*;

    // a stalled transaction keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_payload_byte)
            && $stable(o_byte_index) && $stable(o_status) && $stable(o_seq_number))
        else $error("output changed while stalled");

    // payload bytes carry no status and no length
    a_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_PAYLOAD |-> o_status == ST_OK && o_frame_len == 11'd0)
        else $error("payload result with status fields set");

    // length only on a good packet
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_STATUS && o_status != ST_OK |-> o_frame_len == 11'd0)
        else $error("length on failed status");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_STATUS && o_status == ST_OK |-> o_frame_len != 11'd0)
        else $error("ok status without length");

endmodule

bind ymodem_packet_receiver ymr_checker u_ymr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_kind          (o_kind),
    .o_payload_byte  (o_payload_byte),
    .o_byte_index    (o_byte_index),
    .o_status        (o_status),
    .o_seq_number    (o_seq_number),
    .o_frame_len     (o_frame_len)
);
